@@ rtl/mwo_pkg.sv @@
package mwo_pkg;

  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_N = 1 << SINE_TABLE_BITS;
  localparam int unsigned SINE_QTR = SINE_N / 4;
  localparam int unsigned FRAC_BITS = 24 - SINE_TABLE_BITS;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [3:0] WF_VA    = 4'd0;
  localparam logic [3:0] WF_WT    = 4'd1;
  localparam logic [3:0] WF_FM    = 4'd2;
  localparam logic [3:0] WF_PM    = 4'd3;
  localparam logic [3:0] WF_VEC   = 4'd4;
  localparam logic [3:0] WF_CHIP  = 4'd5;
  localparam logic [3:0] WF_NOISE = 4'd6;
  localparam logic [3:0] WF_RES   = 4'd7;

  typedef enum logic [3:0] {
    PS_P, PS_2P, PS_3P, PS_2P_OFF, PS_FM, PS_PMOD, PS_R1, PS_R2, PS_PW, PS_PHALF
  } psel_e;

  typedef enum logic [3:0] {
    A_SAW, A_PULSE, A_WT1, A_WT2, A_V1, A_V2, A_ADDS, A_CH1, A_CH2, A_CHQ,
    A_R1, A_R2, A_NOISE
  } acc_e;

  typedef struct packed {
    logic  load;
    logic  ph_en;
    psel_e psel;
    logic  sin_look;
    logic  sin_interp;
    logic  blep_set;
    logic  div_step;
    logic  blep_sq;
    logic  mul1;
    logic  mul2;
    logic  acc_en;
    acc_e  acc;
    logic  out_wr;
  } cmd_t;

  typedef struct packed {
    logic [3:0] wf;
    logic       out_busy;
  } sts_t;

  typedef logic [SINE_QTR:0][16:0] qtab_t;

  function automatic logic [63:0] sqstep(logic [63:0] t, logic [63:0] x);
    return (((t * x) >> 30) * x) >> 30;
  endfunction

  function automatic logic [16:0] quarter_sine(int unsigned j);
    logic [63:0] x;
    logic [63:0] t;
    logic signed [63:0] s;
    x = ((PI_Q30 * 64'd2) * 64'(j)) >> SINE_TABLE_BITS;
    t = x;
    s = signed'(x);
    t = sqstep(t, x) / 64'd6;   s = s - signed'(t);
    t = sqstep(t, x) / 64'd20;  s = s + signed'(t);
    t = sqstep(t, x) / 64'd42;  s = s - signed'(t);
    t = sqstep(t, x) / 64'd72;  s = s + signed'(t);
    t = sqstep(t, x) / 64'd110; s = s - signed'(t);
    t = sqstep(t, x) / 64'd156; s = s + signed'(t);
    t = sqstep(t, x) / 64'd210; s = s - signed'(t);
    t = sqstep(t, x) / 64'd272; s = s + signed'(t);
    t = sqstep(t, x) / 64'd342; s = s - signed'(t);
    t = sqstep(t, x) / 64'd420; s = s + signed'(t);
    t = sqstep(t, x) / 64'd506; s = s - signed'(t);
    if (s < 0) s = 64'sd0;
    s = (s + 64'sd8192) >>> 14;
    if (s > 64'sd65536) s = 64'sd65536;
    return s[16:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int unsigned j = 0; j <= SINE_QTR; j++) begin
      t[j] = quarter_sine(j);
    end
    return t;
  endfunction

  localparam qtab_t QSINE = build_qtab();

  function automatic logic signed [17:0] sine_at(logic [SINE_TABLE_BITS-1:0] k);
    logic [SINE_TABLE_BITS-3:0] r;
    logic [SINE_TABLE_BITS-2:0] idx;
    logic signed [17:0] v;
    r = k[SINE_TABLE_BITS-3:0];
    idx = k[SINE_TABLE_BITS-2] ? ((SINE_TABLE_BITS-1)'(SINE_QTR) - {1'b0, r})
                               : {1'b0, r};
    v = signed'({1'b0, QSINE[idx]});
    return k[SINE_TABLE_BITS-1] ? -v : v;
  endfunction

endpackage

@@ rtl/multi_waveform_oscillator_core.sv @@
// Multi-waveform oscillator: each input beat carries a waveform selector, a Q0.24 phase, a
// Q0.24 phase step and a Q1.16 shape amount, and yields one saturated Q2.16 sample beat.
// A controller steps a shared datapath through a short micro-program per waveform: noise is
// one accumulate step, plain sine one sine evaluation, and the other shapes are built from two
// or three sines, while saw/pulse and chip square each run two polyBLEP corrections. Those long
// cases are set by the bit-serial divider of the polyBLEP correction, which runs once for each
// of its two corrections. A new input beat is taken while the previous sample still
// waits in the output register; a finished sample waits until that register is free.
module multi_waveform_oscillator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         waveform_i,
  input  logic [23:0]        phase_i,
  input  logic [23:0]        phase_step_i,
  input  logic [16:0]        shape_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] sample_o
);
  import mwo_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mwo_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .waveform_i   (waveform_i),
    .phase_i      (phase_i),
    .phase_step_i (phase_step_i),
    .shape_i      (shape_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o)
  );

endmodule

@@ rtl/mwo_ctrl.sv @@
module mwo_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mwo_pkg::sts_t sts_i,
  output mwo_pkg::cmd_t cmd_o
);
  import mwo_pkg::*;

  typedef enum logic [2:0] {
    K_PHASE, K_SIN, K_BLEP, K_MUL1, K_MUL2, K_ACC, K_DONE
  } kind_e;

  typedef struct packed {
    kind_e kind;
    psel_e psel;
    acc_e  acc;
  } uop_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_EXEC  = 9'b000000100,
    S_SIN_A = 9'b000001000,
    S_SIN_B = 9'b000010000,
    S_BSET  = 9'b000100000,
    S_BDIV  = 9'b001000000,
    S_BSQ   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  localparam uop_t OP_SIN  = '{K_SIN, PS_P, A_ADDS};
  localparam uop_t OP_BLEP = '{K_BLEP, PS_P, A_ADDS};
  localparam uop_t OP_MUL1 = '{K_MUL1, PS_P, A_ADDS};
  localparam uop_t OP_MUL2 = '{K_MUL2, PS_P, A_ADDS};
  localparam uop_t OP_DONE = '{K_DONE, PS_P, A_ADDS};

  function automatic uop_t op_ph(psel_e ps);
    return '{K_PHASE, ps, A_ADDS};
  endfunction

  function automatic uop_t op_acc(acc_e a);
    return '{K_ACC, PS_P, a};
  endfunction

  function automatic uop_t prog(logic [3:0] wf, logic [3:0] pc);
    uop_t u;
    u = OP_DONE;
    unique case (wf)
      WF_VA: begin
        case (pc)
          4'd0: u = op_ph(PS_P);
          4'd1: u = OP_BLEP;
          4'd2: u = op_acc(A_SAW);
          4'd3: u = op_ph(PS_PW);
          4'd4: u = OP_BLEP;
          4'd5: u = op_acc(A_PULSE);
          default: u = OP_DONE;
        endcase
      end
      WF_WT: begin
        case (pc)
          4'd0: u = op_ph(PS_P);
          4'd1: u = OP_SIN;
          4'd2: u = op_acc(A_WT1);
          4'd3: u = op_ph(PS_2P_OFF);
          4'd4: u = OP_SIN;
          4'd5: u = op_acc(A_WT2);
          default: u = OP_DONE;
        endcase
      end
      WF_FM, WF_PM: begin
        case (pc)
          4'd0: u = op_ph((wf == WF_FM) ? PS_FM : PS_3P);
          4'd1: u = OP_SIN;
          4'd2: u = OP_MUL1;
          4'd3: u = OP_MUL2;
          4'd4: u = op_ph(PS_PMOD);
          4'd5: u = OP_SIN;
          4'd6: u = op_acc(A_ADDS);
          default: u = OP_DONE;
        endcase
      end
      WF_VEC: begin
        case (pc)
          4'd0: u = op_ph(PS_P);
          4'd1: u = OP_SIN;
          4'd2: u = op_acc(A_V1);
          4'd3: u = op_ph(PS_2P);
          4'd4: u = OP_SIN;
          4'd5: u = op_acc(A_V2);
          default: u = OP_DONE;
        endcase
      end
      WF_CHIP: begin
        case (pc)
          4'd0: u = op_ph(PS_P);
          4'd1: u = OP_BLEP;
          4'd2: u = op_acc(A_CH1);
          4'd3: u = op_ph(PS_PHALF);
          4'd4: u = OP_BLEP;
          4'd5: u = op_acc(A_CH2);
          4'd6: u = op_acc(A_CHQ);
          default: u = OP_DONE;
        endcase
      end
      WF_NOISE: begin
        case (pc)
          4'd0: u = op_acc(A_NOISE);
          default: u = OP_DONE;
        endcase
      end
      WF_RES: begin
        case (pc)
          4'd0: u = op_ph(PS_P);
          4'd1: u = OP_SIN;
          4'd2: u = op_acc(A_ADDS);
          4'd3: u = op_ph(PS_R1);
          4'd4: u = OP_SIN;
          4'd5: u = op_acc(A_R1);
          4'd6: u = op_ph(PS_R2);
          4'd7: u = OP_SIN;
          4'd8: u = op_acc(A_R2);
          default: u = OP_DONE;
        endcase
      end
      default: begin
        case (pc)
          4'd0: u = op_ph(PS_P);
          4'd1: u = OP_SIN;
          4'd2: u = op_acc(A_ADDS);
          default: u = OP_DONE;
        endcase
      end
    endcase
    return u;
  endfunction

  function automatic state_e entry(kind_e k);
    state_e s;
    unique case (k)
      K_SIN:   s = S_SIN_A;
      K_BLEP:  s = S_BSET;
      K_DONE:  s = S_DONE;
      default: s = S_EXEC;
    endcase
    return s;
  endfunction

  state_e     state_q, state_d;
  logic [3:0] pc_q, pc_d;
  logic [3:0] cnt_q, cnt_d;
  logic [3:0] pc_n;
  uop_t       uop, nxt;

  assign pc_n = pc_q + 4'd1;
  assign uop  = prog(sts_i.wf, pc_q);
  assign nxt  = prog(sts_i.wf, pc_n);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.psel = uop.psel;
    cmd_o.acc  = uop.acc;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        pc_d = 4'd0;
        state_d = entry(prog(sts_i.wf, 4'd0).kind);
      end
      S_EXEC: begin
        unique case (uop.kind)
          K_PHASE: cmd_o.ph_en = 1'b1;
          K_ACC:   cmd_o.acc_en = 1'b1;
          K_MUL1:  cmd_o.mul1 = 1'b1;
          K_MUL2:  cmd_o.mul2 = 1'b1;
          default: ;
        endcase
        pc_d = pc_n;
        state_d = entry(nxt.kind);
      end
      S_SIN_A: begin
        cmd_o.sin_look = 1'b1;
        state_d = S_SIN_B;
      end
      S_SIN_B: begin
        cmd_o.sin_interp = 1'b1;
        pc_d = pc_n;
        state_d = entry(nxt.kind);
      end
      S_BSET: begin
        cmd_o.blep_set = 1'b1;
        cnt_d = 4'd0;
        state_d = S_BDIV;
      end
      S_BDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = S_BSQ;
        end
      end
      S_BSQ: begin
        cmd_o.blep_sq = 1'b1;
        pc_d = pc_n;
        state_d = entry(nxt.kind);
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_wr = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= 4'd0;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/mwo_dp.sv @@
module mwo_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [3:0]          waveform_i,
  input  logic [23:0]         phase_i,
  input  logic [23:0]         phase_step_i,
  input  logic [16:0]         shape_i,
  input  mwo_pkg::cmd_t       cmd_i,
  output mwo_pkg::sts_t       sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [17:0]  sample_o
);
  import mwo_pkg::*;

  localparam int unsigned CHIP_N = 32;
  localparam logic [31:0] NOISE_SEED = 32'd2463534242;
  localparam logic [23:0] HALF = 24'h800000;
  localparam logic [23:0] DT_MIN = 24'd17;
  localparam logic [23:0] DT_MAX = 24'd8220836;
  localparam logic [32:0] RES_LIMIT = 33'd771751936;

  typedef logic [CHIP_N-1:0][17:0] ctab_t;

  function automatic ctab_t build_ctab();
    ctab_t t;
    for (int unsigned i = 0; i < CHIP_N; i++) begin
      t[i] = 18'((i * 131072 + 7) / 14);
    end
    return t;
  endfunction

  localparam ctab_t CHIP_LVL = build_ctab();

  logic [3:0]  wf_q;
  logic [23:0] p_q, step_q, dt_q, ph_q, ph_d, rem_q;
  logic [16:0] sh_q;
  logic signed [17:0] a_q, b_q, s_q, bl_q, b0_q;
  logic [FRAC_BITS-1:0] fr_q;
  logic [15:0] quo_q;
  logic        bneg_q, bzero_q;
  logic signed [41:0] t_q;
  logic signed [59:0] prod_q;
  logic signed [23:0] acc_q, acc_d;
  logic [31:0] noise_q, n1, n2, n3;
  logic        out_valid_q;
  logic signed [17:0] sample_q;

  logic [39:0] wm;
  logic signed [25:0] wr;
  logic [23:0] w, w_q;
  logic [40:0] offm;
  logic [50:0] fmm, r1m, r2m;

  always_comb begin
    wm = {23'b0, sh_q} * 40'd5368709;
    wr = 26'sd11072963 - signed'({2'b0, wm[39:16]});
    if (wr < 26'sd2013266) w = 24'd2013266;
    else if (wr > 26'sd14763950) w = 24'd14763950;
    else w = wr[23:0];
    offm = {24'b0, sh_q} * 41'd13350884;
    fmm = {27'b0, p_q} * 51'd33721958;
    r1m = {27'b0, p_q} * 51'd34057503;
    r2m = {27'b0, p_q} * 51'd66605793;
    unique case (cmd_i.psel)
      PS_P:      ph_d = p_q;
      PS_2P:     ph_d = {p_q[22:0], 1'b0};
      PS_3P:     ph_d = p_q + {p_q[22:0], 1'b0};
      PS_2P_OFF: ph_d = {p_q[22:0], 1'b0} + offm[39:16];
      PS_FM:     ph_d = fmm[47:24];
      PS_PMOD:   ph_d = p_q + prod_q[55:32];
      PS_R1:     ph_d = r1m[47:24];
      PS_R2:     ph_d = r2m[47:24];
      PS_PW:     ph_d = p_q - w_q;
      PS_PHALF:  ph_d = p_q ^ HALF;
      default:   ph_d = p_q;
    endcase
  end

  logic [SINE_TABLE_BITS-1:0] sidx;
  logic signed [18:0] sdiff;
  logic signed [18+FRAC_BITS:0] dfr;

  assign sidx  = ph_q[23 -: SINE_TABLE_BITS];
  assign sdiff = 19'(b_q) - 19'(a_q);
  assign dfr   = (19+FRAC_BITS)'(sdiff) * signed'((19+FRAC_BITS)'({1'b0, fr_q}));

  logic        lo, hi, ge;
  logic [24:0] tail, r2;
  logic [16:0] dlin;
  logic [33:0] dd;
  logic [33:0] dv;

  assign lo   = ph_q < dt_q;
  assign hi   = {1'b0, ph_q} > (25'h1000000 - {1'b0, dt_q});
  assign tail = 25'h1000000 - {1'b0, ph_q};
  assign r2   = {rem_q, 1'b0};
  assign ge   = r2 >= {1'b0, dt_q};
  assign dlin = 17'd65536 - {1'b0, quo_q};
  assign dd   = {17'b0, dlin} * {17'b0, dlin};
  assign dv   = (dd + 34'd32768) >> 16;

  logic signed [19:0] ma, mb;
  logic signed [39:0] mp;
  logic signed [23:0] mres;
  logic signed [19:0] one_m_sh, shs, saw, pls;
  logic signed [23:0] q7, mag, nsum;
  logic               r1_ok, r2_ok;
  logic [32:0]        r1t, r2t;

  assign one_m_sh = 20'sd65536 - signed'({3'b0, sh_q});
  assign shs      = signed'({3'b0, sh_q});
  assign saw      = signed'({3'b0, p_q[23:7]}) - 20'sd65536 - 20'(bl_q);
  assign pls      = ((p_q < w_q) ? 20'sd65536 : -20'sd65536) + 20'(b0_q) - 20'(bl_q);
  assign r1t      = {9'b0, step_q} * 33'd203;
  assign r2t      = {9'b0, step_q} * 33'd397;
  assign r1_ok    = r1t < RES_LIMIT;
  assign r2_ok    = r2t < RES_LIMIT;
  assign q7       = (acc_q <<< 3) - acc_q;
  assign mag      = (q7 < 0) ? -q7 : q7;
  assign nsum     = mag + 24'sd32768;
  assign n1       = noise_q ^ (noise_q << 13);
  assign n2       = n1 ^ (n1 >> 17);
  assign n3       = n2 ^ (n2 << 5);

  always_comb begin
    ma = 20'sd0;
    mb = 20'sd0;
    unique case (cmd_i.acc)
      A_SAW:   begin ma = saw;        mb = one_m_sh; end
      A_PULSE: begin ma = pls;        mb = shs;      end
      A_WT1:   begin ma = 20'sd47186; mb = 20'(s_q); end
      A_WT2:   begin ma = 20'sd18350; mb = 20'(s_q); end
      A_V1:    begin ma = one_m_sh;   mb = 20'(s_q); end
      A_V2:    begin ma = shs;        mb = 20'(s_q); end
      A_R1:    begin ma = 20'sd26214; mb = 20'(s_q); end
      A_R2:    begin ma = 20'sd13107; mb = 20'(s_q); end
      default: ;
    endcase
    mp   = ma * mb + 40'sd32768;
    mres = mp[39:16];
    unique case (cmd_i.acc)
      A_SAW:   acc_d = mres;
      A_PULSE, A_WT1, A_WT2, A_V1, A_V2: acc_d = acc_q + mres;
      A_ADDS:  acc_d = acc_q + 24'(s_q);
      A_CH1:   acc_d = ((p_q < HALF) ? 24'sd65536 : -24'sd65536) + 24'(bl_q);
      A_CH2:   acc_d = acc_q - 24'(bl_q);
      A_CHQ:   acc_d = (q7 < 0) ? -24'(signed'(CHIP_LVL[nsum[20:16]]))
                                :  24'(signed'(CHIP_LVL[nsum[20:16]]));
      A_R1:    acc_d = r1_ok ? acc_q + mres : acc_q;
      A_R2:    acc_d = r2_ok ? acc_q + mres : acc_q;
      A_NOISE: acc_d = signed'({7'b0, n3[31:15]}) - 24'sd65536;
      default: acc_d = acc_q;
    endcase
  end

  logic signed [17:0] sat;
  assign sat = (acc_q > 24'sd131071) ? 18'sd131071 :
               (acc_q < -24'sd131072) ? -18'sd131072 : acc_q[17:0];

  always_ff @(posedge clk_i) begin
    w_q <= w;
    if (cmd_i.load) begin
      wf_q   <= waveform_i;
      p_q    <= phase_i;
      step_q <= phase_step_i;
      dt_q   <= (phase_step_i < DT_MIN) ? DT_MIN :
                (phase_step_i > DT_MAX) ? DT_MAX : phase_step_i;
      sh_q   <= (shape_i > 17'd65536) ? 17'd65536 : shape_i;
      acc_q  <= 24'sd0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.acc_en && cmd_i.acc == A_SAW) begin
      b0_q <= bl_q;
    end
    if (cmd_i.ph_en) begin
      ph_q <= ph_d;
    end
    if (cmd_i.sin_look) begin
      a_q  <= sine_at(sidx);
      b_q  <= sine_at(sidx + 1'b1);
      fr_q <= ph_q[FRAC_BITS-1:0];
    end
    if (cmd_i.sin_interp) begin
      s_q <= a_q + dfr[FRAC_BITS +: 18];
    end
    if (cmd_i.blep_set) begin
      rem_q   <= lo ? ph_q : (hi ? tail[23:0] : 24'd0);
      quo_q   <= 16'd0;
      bneg_q  <= lo;
      bzero_q <= ~lo & ~hi;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 24'(r2 - {1'b0, dt_q}) : r2[23:0];
      quo_q <= {quo_q[14:0], ge};
    end
    if (cmd_i.blep_sq) begin
      bl_q <= bzero_q ? 18'sd0 :
              (bneg_q ? -signed'(dv[17:0]) : signed'(dv[17:0]));
    end
    if (cmd_i.mul1) begin
      t_q <= 42'(s_q) * ((wf_q == WF_FM) ? 42'sd8010531 : 42'sd5340354);
    end
    if (cmd_i.mul2) begin
      prod_q <= 60'(t_q) * signed'({43'b0, sh_q});
    end
    if (cmd_i.out_wr) begin
      sample_q <= sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q     <= NOISE_SEED;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_en && cmd_i.acc == A_NOISE) begin
        noise_q <= n3;
      end
      if (cmd_i.out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.wf       = wf_q;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign sample_o       = sample_q;

endmodule

@@ verif/multi_waveform_oscillator_core_tb.sv @@
module multi_waveform_oscillator_core_tb;
  import mwo_pkg::*;

  localparam longint ONE_Q16 = 65536;
  localparam longint MASK24 = 64'hFFFFFF;
  localparam longint STEP_MIN = 17;
  localparam longint STEP_MAX = 8220836;
  localparam longint PI_Q30_L = 64'd3373259426;
  localparam int unsigned NOISE_SEED = 32'd2463534242;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [3:0]         waveform_i;
  logic [23:0]        phase_i;
  logic [23:0]        phase_step_i;
  logic [16:0]        shape_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [17:0] sample_o;

  longint             sine_lut[SINE_N];
  int unsigned        noise_word;
  logic signed [17:0] sample_queue[$];
  int                 in_idle_pct;
  int                 out_idle_pct;
  int                 errors;
  int                 beats_sent;
  int                 beats_checked;
  int                 cycles;

  multi_waveform_oscillator_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .waveform_i   (waveform_i),
    .phase_i      (phase_i),
    .phase_step_i (phase_step_i),
    .shape_i      (shape_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_o     (sample_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint taylor_quarter(longint j);
    longint x;
    longint term;
    longint sum;
    x = ((2 * PI_Q30_L) * j) >> SINE_TABLE_BITS;
    term = x;
    sum = x;
    for (int n = 1; n <= 11; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = 0;
    sum = (sum + 8192) >> 14;
    if (sum > ONE_Q16) sum = ONE_Q16;
    return sum;
  endfunction

  function automatic void fill_sine_lut();
    longint q;
    longint v;
    q = SINE_N / 4;
    for (int k = 0; k < SINE_N; k++) begin
      v = ((k / q) % 2 == 1) ? taylor_quarter(q - k % q) : taylor_quarter(k % q);
      sine_lut[k] = ((k / q) >= 2) ? -v : v;
    end
  endfunction

  function automatic longint round_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic longint sine_interp(longint ph);
    longint p;
    longint idx;
    longint frac;
    longint a;
    longint b;
    p = ph & MASK24;
    idx = p >> FRAC_BITS;
    frac = p & ((64'd1 << FRAC_BITS) - 1);
    a = sine_lut[idx % SINE_N];
    b = sine_lut[(idx + 1) % SINE_N];
    return a + (((b - a) * frac) >>> FRAC_BITS);
  endfunction

  function automatic longint ratio_phase(longint p, longint m);
    return ((p * m) >> 24) & MASK24;
  endfunction

  function automatic longint blep_corr(longint ph, longint dt);
    longint x;
    longint d;
    if (ph < dt) begin
      x = (ph << 16) / dt;
      d = ONE_Q16 - x;
      return -((d * d + 32768) >> 16);
    end
    if (ph > (64'd1 << 24) - dt) begin
      x = (((64'd1 << 24) - ph) << 16) / dt;
      d = ONE_Q16 - x;
      return (d * d + 32768) >> 16;
    end
    return 0;
  endfunction

  function automatic logic signed [17:0] oscillator_sample(logic [3:0] wf, logic [23:0] ph_in,
                                                           logic [23:0] st_in,
                                                           logic [16:0] sh_in);
    longint p;
    longint st;
    longint sh;
    longint dt;
    longint y;
    longint saw;
    longint w;
    longint pulse;
    longint m;
    longint q;
    longint mag;
    longint n;
    p = ph_in;
    st = st_in;
    sh = (sh_in > ONE_Q16) ? ONE_Q16 : sh_in;
    dt = (st < STEP_MIN) ? STEP_MIN : ((st > STEP_MAX) ? STEP_MAX : st);
    case (wf)
      WF_VA: begin
        saw = (p >> 7) - ONE_Q16 - blep_corr(p, dt);
        w = 11072963 - ((sh * 5368709) >> 16);
        if (w < 2013266) w = 2013266;
        if (w > 14763950) w = 14763950;
        pulse = (p < w) ? ONE_Q16 : -ONE_Q16;
        pulse = pulse + blep_corr(p, dt);
        pulse = pulse - blep_corr((p + (64'd1 << 24) - w) & MASK24, dt);
        y = round_mul(saw, ONE_Q16 - sh) + round_mul(pulse, sh);
      end
      WF_WT: begin
        y = round_mul(47186, sine_interp(p))
          + round_mul(18350, sine_interp(2 * p + ((sh * 13350884) >> 16)));
      end
      WF_FM: begin
        m = sh * sine_interp(ratio_phase(p, 33721958));
        y = sine_interp(p + ((m * 8010531) >>> 32));
      end
      WF_PM: begin
        m = sh * sine_interp(3 * p);
        y = sine_interp(p + ((m * 5340354) >>> 32));
      end
      WF_VEC: begin
        y = round_mul(ONE_Q16 - sh, sine_interp(p)) + round_mul(sh, sine_interp(2 * p));
      end
      WF_CHIP: begin
        q = (p < 64'h800000) ? ONE_Q16 : -ONE_Q16;
        q = q + blep_corr(p, dt);
        q = q - blep_corr((p - 64'h800000) & MASK24, dt);
        q = q * 7;
        mag = (q < 0) ? -q : q;
        n = (mag + 32768) >> 16;
        mag = (n * 131072 + 7) / 14;
        y = (q < 0) ? -mag : mag;
      end
      WF_NOISE: begin
        noise_word = noise_word ^ (noise_word << 13);
        noise_word = noise_word ^ (noise_word >> 17);
        noise_word = noise_word ^ (noise_word << 5);
        y = longint'(noise_word >> 15) - ONE_Q16;
      end
      WF_RES: begin
        y = sine_interp(p);
        if (st * 203 < 771751936) y = y + round_mul(26214, sine_interp(ratio_phase(p, 34057503)));
        if (st * 397 < 771751936) y = y + round_mul(13107, sine_interp(ratio_phase(p, 66605793)));
      end
      default: y = sine_interp(p);
    endcase
    if (y > 131071) y = 131071;
    if (y < -131072) y = -131072;
    return y[17:0];
  endfunction

  task automatic send_beat(logic [3:0] wf, logic [23:0] ph, logic [23:0] st, logic [16:0] sh);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    waveform_i <= wf;
    phase_i <= ph;
    phase_step_i <= st;
    shape_i <= sh;
    do @(posedge clk_i); while (!in_ready_o);
    sample_queue.push_back(oscillator_sample(wf, ph, st, sh));
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_phase();
    case ($urandom_range(5))
      0: return 24'($urandom_range(40000));
      1: return 24'hFFFFFF - 24'($urandom_range(40000));
      2: return 24'h800000 + 24'($urandom_range(60000)) - 24'd30000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_step();
    case ($urandom_range(6))
      0: return 24'($urandom_range(20));
      1: return 24'($urandom_range(24'hFFFFFF, 8200000));
      2: return 24'($urandom_range(4000000, 1900000));
      3: return 24'($urandom_range(200000));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_shape();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic test_directed();
    for (int wf = 0; wf < 16; wf++) begin
      send_beat(4'(wf), 24'($urandom), 24'($urandom_range(100000)), 17'($urandom_range(65536)));
    end
    send_beat(WF_VA, 24'd0, 24'd0, 17'd0);
    send_beat(WF_VA, 24'hFFFFFF, 24'hFFFFFF, 17'd131071);
    send_beat(WF_VA, 24'd100, 24'd8220836, 17'd65536);
    send_beat(WF_CHIP, 24'h7FFFFF, 24'd17, 17'd32768);
    send_beat(WF_CHIP, 24'h800000, 24'd8220837, 17'd0);
    send_beat(WF_RES, 24'h123456, 24'd3801733, 17'd0);
    send_beat(WF_RES, 24'h123456, 24'd3801734, 17'd0);
    send_beat(WF_RES, 24'h654321, 24'd1943959, 17'd0);
    send_beat(WF_RES, 24'h654321, 24'd1943960, 17'd0);
    wait_drained();
  endtask

  task automatic test_random(int n_beats, int in_pct, int out_pct);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < n_beats; i++) begin
      send_beat(4'($urandom_range(15)), pick_phase(), pick_step(), pick_shape());
    end
    wait_drained();
  endtask

  task automatic test_pause_until_empty();
    in_idle_pct = 0;
    out_idle_pct = 50;
    for (int i = 0; i < 20; i++) begin
      send_beat(4'($urandom_range(15)), pick_phase(), pick_step(), pick_shape());
      if (i % 5 == 4) wait_drained();
    end
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (sample_queue.size() == 0) begin
          $display("%0t: unexpected sample beat, actual %0d", $time, sample_o);
          errors++;
        end else begin
          if (sample_o !== sample_queue[0]) begin
            $display("%0t: sample mismatch, expected %0d actual %0d", $time,
                     sample_queue[0], sample_o);
            errors++;
          end
          void'(sample_queue.pop_front());
          beats_checked++;
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("multi_waveform_oscillator_core regression: fail");
      $finish;
    end
  end

  initial begin
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    cycles = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    noise_word = NOISE_SEED;
    fill_sine_lut();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    waveform_i = '0;
    phase_i = '0;
    phase_step_i = '0;
    shape_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(420, 35, 81);
    test_random(420, 81, 35);
    test_pause_until_empty();
    test_random(420, 0, 0);
    $display("Sent %0d input beats over all waveform selectors, checked %0d samples,", beats_sent,
             beats_checked);
    $display("with step clamp, shape saturation and resonator partial cutoffs covered.");
    if (errors == 0) begin
      $display("multi_waveform_oscillator_core regression: pass");
    end else begin
      $display("multi_waveform_oscillator_core regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mwo_pkg.sv
rtl/mwo_ctrl.sv
rtl/mwo_dp.sv
rtl/multi_waveform_oscillator_core.sv
verif/multi_waveform_oscillator_core_tb.sv
